>>> design/mpr_pkg.sv
// shared constants and types for the median prediction pixel reconstruction block
package mpr_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    localparam int PIX_W     = 8;
    localparam int RES_W     = 9;
    localparam int PWIDTH_W  = 13;
    localparam int PHEIGHT_W = 16;
    localparam int ROW_W     = 16;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_HEIGHT = 1'b1;

    localparam logic [PWIDTH_W-1:0]  PLANE_WIDTH_RST  = 13'd4096;
    localparam logic [PHEIGHT_W-1:0] PLANE_HEIGHT_RST = 16'd2160;

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t pixel;
        logic row_end;
        logic frame_end;
    } result_t;

    // median edge detector on left, above and upper-left
    function automatic pix_t med_predict(input pix_t a, input pix_t b, input pix_t c);
        pix_t lo;
        pix_t hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        if (c >= hi)
            return lo;
        else if (c <= lo)
            return hi;
        else
            return pix_t'(a + b - c);
    endfunction

endpackage

>>> design/mpr_ram.sv
// generic single write port, single read port ram with registered read
module mpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> design/med_prediction_pixel_reconstruct.sv
// top level: raster order pixel reconstruction from residuals with a line store
// the pixel of a residual transfer is registered into the output stage
// throughput: one pixel per cycle while neither side stalls; the line store ram has one read and one write port
// the read for the next column is issued in the transfer cycle, so no bubble between pixels
// a two entry output stage keeps input transfers going while a result waits
// reset: position, neighbors and valid flags cleared, plane size set to defaults; line store contents undefined
module med_prediction_pixel_reconstruct (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [mpr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mpr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [mpr_pkg::RES_W-1:0] residual,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [mpr_pkg::PIX_W-1:0]      pixel,
    output logic                           row_end,
    output logic                           frame_end
);

    import mpr_pkg::*;

    logic [PWIDTH_W-1:0]  plane_width_reg;
    logic [PHEIGHT_W-1:0] plane_height_reg;
    logic [COL_W-1:0]     col_reg;
    logic [COL_W-1:0]     col_next;
    logic [ROW_W-1:0]     row_reg;
    logic [ROW_W-1:0]     row_next;
    pix_t                 left_reg;
    pix_t                 upper_left_reg;
    logic                 byp_valid_reg;
    pix_t                 byp_data_reg;

    result_t main_reg;
    result_t skid_reg;
    logic    main_valid_reg;
    logic    skid_valid_reg;

    logic                 in_fire;
    logic                 out_fire;
    logic [COL_W:0]       w_eff;
    logic [PHEIGHT_W-1:0] h_eff;
    logic [COL_W-1:0]     rd_addr;
    pix_t                 ram_rd_data;
    pix_t                 above;
    pix_t                 pred;
    pix_t                 pix;
    logic                 row_end_c;
    logic                 frame_end_c;
    result_t              res_c;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= PLANE_WIDTH_RST;
            plane_height_reg <= PLANE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_PLANE_WIDTH:  plane_width_reg  <= cfg_data[PWIDTH_W-1:0];
                REG_PLANE_HEIGHT: plane_height_reg <= cfg_data[PHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective plane size
    always_comb
    begin
        if (plane_width_reg == '0)
            w_eff = (COL_W+1)'(1);
        else if (32'(plane_width_reg) > MAX_WIDTH)
            w_eff = (COL_W+1)'(MAX_WIDTH);
        else
            w_eff = (COL_W+1)'(plane_width_reg);
        h_eff = (plane_height_reg == '0) ? PHEIGHT_W'(1) : plane_height_reg;
    end

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // same entry written last transfer and read now: ram still returned the old value
    assign above = byp_valid_reg ? byp_data_reg : ram_rd_data;

    always_comb
    begin
        if (row_reg == '0 && col_reg == '0)
            pred = '0;
        else if (row_reg == '0)
            pred = left_reg;
        else if (col_reg == '0)
            pred = above;
        else
            pred = med_predict(left_reg, above, upper_left_reg);
        pix = pix_t'(residual[PIX_W-1:0] + pred);

        row_end_c   = ({1'b0, col_reg} + (COL_W+1)'(1)) >= w_eff;
        frame_end_c = row_end_c && (({1'b0, row_reg} + 17'd1) >= {1'b0, h_eff});

        if (row_end_c)
        begin
            col_next = '0;
            row_next = frame_end_c ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end

        res_c.pixel     = pix;
        res_c.row_end   = row_end_c;
        res_c.frame_end = frame_end_c;
    end

    // look ahead so the above value of the next column is ready at the next transfer
    assign rd_addr = in_fire ? col_next : col_reg;

    mpr_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (in_fire),
        .wr_addr (col_reg),
        .wr_data (pix),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
            byp_valid_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            col_reg        <= col_next;
            row_reg        <= row_next;
            left_reg       <= pix;
            upper_left_reg <= above;
            byp_valid_reg  <= (col_next == col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byp_data_reg <= pix;
        end
    end

    // output stage with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                main_reg <= skid_reg;
        end
        else if (in_fire)
        begin
            if (main_valid_reg && !out_fire)
                skid_reg <= res_c;
            else
                main_reg <= res_c;
        end
    end

    assign out_valid = main_valid_reg;
    assign pixel     = main_reg.pixel;
    assign row_end   = main_reg.row_end;
    assign frame_end = main_reg.frame_end;

    // checks
    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while main entry empty");

    a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_end_c |=> col_reg == '0 && row_reg == '0)
        else $error("position did not wrap at frame end");

    a_frame_end_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && frame_end_c |-> row_end_c)
        else $error("frame end without row end");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !row_end_c |=> {1'b0, col_reg} < w_eff || $past(cfg_valid))
        else $error("column ran past plane width");

endmodule

>>> dv/med_prediction_pixel_reconstruct_tb.sv
// testbench for the median prediction pixel reconstruction block with a self-checking scoreboard
`timescale 1ns / 100ps

module med_prediction_pixel_reconstruct_tb;

    import mpr_pkg::*;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 3;
    localparam int LATENCY        = 1;
    localparam int HOLD_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 12;
    localparam int MAX_REPORTS    = 10;
    localparam int FILL_ITEMS     = 96;

    // reconstruction predictor and store of expected pixels
    class pixel_scoreboard;
        pix_t                  line_store [MAX_WIDTH];
        pix_t                  left_pix;
        pix_t                  upper_left_pix;
        int unsigned           col;
        int unsigned           row;
        logic [PWIDTH_W-1:0]   width_reg;
        logic [PHEIGHT_W-1:0]  height_reg;
        result_t               expected_q [$];
        int unsigned           error_count;
        int unsigned           residual_count;
        int unsigned           pixel_count;
        int unsigned           frame_count;

        function new();
            foreach (line_store[i])
                line_store[i] = '0;
            left_pix       = '0;
            upper_left_pix = '0;
            col            = 0;
            row            = 0;
            width_reg      = PLANE_WIDTH_RST;
            height_reg     = PLANE_HEIGHT_RST;
            error_count    = 0;
            residual_count = 0;
            pixel_count    = 0;
            frame_count    = 0;
        endfunction

        function void flag(string what);
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("[%0t] error: %s", $realtime, what);
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_PLANE_WIDTH)
                width_reg = data[PWIDTH_W-1:0];
            else if (idx == REG_PLANE_HEIGHT)
                height_reg = data[PHEIGHT_W-1:0];
        endfunction

        function pix_t edge_median(pix_t a, pix_t b, pix_t c);
            if (c >= a && c >= b)
                return (a < b) ? a : b;
            if (c <= a && c <= b)
                return (a < b) ? b : a;
            return pix_t'(a + b - c);
        endfunction

        function void note_residual(logic signed [RES_W-1:0] r);
            int unsigned w;
            int unsigned h;
            int unsigned idx;
            pix_t        above;
            pix_t        pred;
            pix_t        pix;
            result_t     exp_r;
            w = width_reg;
            h = height_reg;
            // out of range sizes are clamped
            if (w < 1)
                w = 1;
            if (w > MAX_WIDTH)
                w = MAX_WIDTH;
            if (h < 1)
                h = 1;
            idx   = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
            above = line_store[idx];
            if (row == 0 && col == 0)
                pred = '0;
            else if (row == 0)
                pred = left_pix;
            else if (col == 0)
                pred = above;
            else
                pred = edge_median(left_pix, above, upper_left_pix);
            // only the low byte of the residual matters modulo 256
            pix = pix_t'(r) + pred;
            line_store[idx] = pix;
            upper_left_pix  = above;
            left_pix        = pix;
            exp_r.pixel     = pix;
            exp_r.row_end   = (col + 1 >= w);
            exp_r.frame_end = exp_r.row_end && (row + 1 >= h);
            if (exp_r.row_end)
            begin
                col = 0;
                row = exp_r.frame_end ? 0 : ((row + 1) & 16'hFFFF);
            end
            else
                col = col + 1;
            if (exp_r.frame_end)
                frame_count++;
            residual_count++;
            expected_q.insert(expected_q.size(), exp_r);
        endfunction

        function void check_pixel(pix_t p, logic re, logic fe);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                flag($sformatf("pixel %0d row_end %0b frame_end %0b with nothing expected",
                               p, re, fe));
                return;
            end
            exp_r = expected_q.pop_front();
            pixel_count++;
            if (p !== exp_r.pixel || re !== exp_r.row_end || fe !== exp_r.frame_end)
                flag($sformatf("pixel #%0d expected %0d/%0b/%0b got %0d/%0b/%0b",
                               pixel_count, exp_r.pixel, exp_r.row_end, exp_r.frame_end,
                               p, re, fe));
        endfunction
    endclass

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_INDEX_W-1:0]        cfg_index = REG_PLANE_WIDTH;
    logic [CFG_DATA_W-1:0]         cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic signed [RES_W-1:0]       residual  = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [PIX_W-1:0]              pixel;
    logic                          row_end;
    logic                          frame_end;

    pixel_scoreboard sb = new();

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    logic        hold_kick      = 1'b0;
    logic        hold_seen      = 1'b0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;
    int unsigned settings_count = 0;

    med_prediction_pixel_reconstruct i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .residual  (residual),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel     (pixel),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // receiver: random stalls, or a long hold-off when kicked
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                sb.note_residual(residual);
            if (out_valid && !out_stall)
                sb.check_pixel(pixel, row_end, frame_end);
            if ((cfg_valid && cfg_ready) || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [RES_W-1:0] random_residual();
        return RES_W'($urandom_range(0, (1 << RES_W) - 1));
    endfunction

    task automatic send_residual(input logic signed [RES_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        residual <= r;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // wait until every expected pixel has been seen, then some extra cycles
    task automatic wait_drained(input int extra);
        do
            @(negedge clk);
        while (sb.expected_q.size() != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        wait_drained(LATENCY + 2);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_plane(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        write_register(REG_PLANE_WIDTH, w);
        write_register(REG_PLANE_HEIGHT, h);
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    task automatic send_list(input int values [$]);
        foreach (values[i])
            send_residual(RES_W'(values[i]));
        end_phase();
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        int                    n;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // part of a first row at the reset width, left prediction only
        recv_stall_pct <= 10;
        for (int i = 0; i < FILL_ITEMS; i++)
            send_residual(random_residual());
        end_phase();
        recv_stall_pct <= 0;

        // zero sizes act as one: the pending row wraps, then every pixel is a frame start
        program_plane(16'd0, 16'd0);
        send_list('{255, -255, -256, 0});
        // 3x4 frame walking all median branches and both wrap directions
        program_plane(16'd3, 16'd4);
        send_list('{100, 100, -150, -70, 0, 5, 255, -255, -256, -30, 1, 7});
        // shrink width then height in the middle of a frame
        program_plane(16'd4, 16'd2);
        send_list('{12, -3, 40});
        program_plane(16'd2, 16'd2);
        send_list('{-128});
        program_plane(16'd2, 16'd1);
        send_list('{127, -1});

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            // a one pixel frame ends the pending frame so each plane starts at its origin
            program_plane(16'd1, 16'd1);
            send_residual(random_residual());
            end_phase();

            case ($urandom_range(9))
                0: w = 16'd0;
                1: w = 16'd1;
                2: w = CFG_DATA_W'(MAX_WIDTH);
                3: w = CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, 16'hFFFF));
                default: w = CFG_DATA_W'($urandom_range(2, 24));
            endcase
            case ($urandom_range(7))
                0: h = 16'd0;
                1: h = 16'd1;
                2: h = 16'hFFFF;
                default: h = CFG_DATA_W'($urandom_range(2, 6));
            endcase
            if (p == 3)
                w = 16'hFFFF;
            if (p == 5)
                h = 16'hFFFF;
            program_plane(w, h);

            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct = 79;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 79;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct <= 10;
                end
            endcase
            // long receiver hold-off while the sender keeps offering
            if (p == 0)
                hold_kick <= ~hold_kick;

            n = $urandom_range(80, 140);
            for (int i = 0; i < n; i++)
            begin
                // sender pauses until the block has fully drained
                if (p == 6 && i == n / 2)
                begin
                    in_valid <= 1'b0;
                    wait_drained(1);
                end
                send_residual(random_residual());
            end
            end_phase();
        end
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        repeat (LATENCY + 4) @(posedge clk);

        if (sb.expected_q.size() != 0)
            sb.flag($sformatf("%0d expected pixels never arrived", sb.expected_q.size()));

        $display("covered %0d residual transfers, %0d pixels checked, %0d frames ended",
                 sb.residual_count, sb.pixel_count, sb.frame_count);
        $display("%0d plane settings incl. zero, one, full and over-range sizes; %0d errors",
                 settings_count, sb.error_count);
        if (sb.error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> sim.f
design/mpr_pkg.sv
design/mpr_ram.sv
design/med_prediction_pixel_reconstruct.sv
dv/med_prediction_pixel_reconstruct_tb.sv
